/* rtl/divider_edge_timer_with_reload_top_defines.svh */
// Assertion macros used by the timer top level.
`ifndef DIVIDER_EDGE_TIMER_WITH_RELOAD_TOP_DEFINES_SVH
`define DIVIDER_EDGE_TIMER_WITH_RELOAD_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DTR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DTR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer assertion failed");

`endif

/* rtl/dtr_pkg.sv */
// Types and constants shared by the divider edge timer.
package dtr_pkg;

  localparam int TICKS_W     = 6;
  localparam int TICKS_EXT_W = TICKS_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int DIV_W       = 16;
  localparam int BYTE_W      = 8;

  localparam logic [DIV_W-1:0] DIV_RESET = 16'hABCC;
  localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;

  // Divider tap positions per clock-select code
  localparam int TAP_SEL0 = 9;
  localparam int TAP_SEL1 = 3;
  localparam int TAP_SEL2 = 5;
  localparam int TAP_SEL3 = 7;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD_VALUE = 2'd2;

  // Configuration write as seen by the timer core
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } dtr_cfg_t;

  // Timer state reported to the sequencer
  typedef struct packed {
    logic [BYTE_W-1:0] divider_high;
    logic [BYTE_W-1:0] count_value;
    logic              tick_irq;
  } dtr_status_t;

endpackage

/* rtl/dtr_core.sv */
// Timer core: divider, tap edge detector, counter and reload delay, one step per tick input.
module dtr_core #(
  parameter int RELOAD_DELAY = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  dtr_pkg::dtr_cfg_t   cfg,
  input  logic                tick,
  output dtr_pkg::dtr_status_t status
);
  import dtr_pkg::*;

  localparam int DLY_W = $clog2(RELOAD_DELAY + 1);

  logic              timer_enable;
  logic [1:0]        clock_select;
  logic [BYTE_W-1:0] reload_value;

  logic [DIV_W-1:0]  divider, divider_next;
  logic [BYTE_W-1:0] counter, counter_next;
  logic              edge_history, edge_history_next;
  logic [DLY_W-1:0]  reload_delay, reload_delay_next;
  logic              tap;
  logic              level;
  logic              irq;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_enable <= 1'b0;
      clock_select <= 2'd0;
      reload_value <= '0;
    end else if (cfg.we) begin
      case (cfg.index)
        REG_TIMER_ENABLE: timer_enable <= cfg.data[0];
        REG_CLOCK_SELECT: clock_select <= cfg.data[1:0];
        REG_RELOAD_VALUE: reload_value <= cfg.data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pick the divider tap after the increment of this tick
  always_comb begin
    case (clock_select)
      2'd0:    tap = divider_next[TAP_SEL0];
      2'd1:    tap = divider_next[TAP_SEL1];
      2'd2:    tap = divider_next[TAP_SEL2];
      default: tap = divider_next[TAP_SEL3];
    endcase
  end

  assign level = tap & timer_enable;

  // Work out one tick
  always_comb begin
    divider_next      = divider;
    counter_next      = counter;
    edge_history_next = edge_history;
    reload_delay_next = reload_delay;
    irq               = 1'b0;
    if (tick) begin
      divider_next = divider + DIV_W'(1);
      if (reload_delay != '0) begin
        // Count the delay down; no edge detection meanwhile
        reload_delay_next = reload_delay - DLY_W'(1);
        if (reload_delay == DLY_W'(1)) begin
          counter_next = reload_value;
          irq          = 1'b1;
        end
      end else begin
        if (edge_history && !level) begin
          if (counter == COUNT_MAX) begin
            counter_next      = '0;
            reload_delay_next = DLY_W'(RELOAD_DELAY);
          end else begin
            counter_next = counter + BYTE_W'(1);
          end
        end
        edge_history_next = level;
      end
    end
  end

  // Hold timer state
  always_ff @(posedge clk) begin
    if (rst) begin
      divider      <= DIV_RESET;
      counter      <= '0;
      edge_history <= 1'b0;
      reload_delay <= '0;
    end else begin
      divider      <= divider_next;
      counter      <= counter_next;
      edge_history <= edge_history_next;
      reload_delay <= reload_delay_next;
    end
  end

  assign status.divider_high = divider[DIV_W-1:DIV_W-BYTE_W];
  assign status.count_value  = counter;
  assign status.tick_irq     = irq;

endmodule

/* rtl/divider_edge_timer_with_reload_top.sv */
// Divider edge timer: tick sequencer, input and output words, configuration port.
// Each input word runs the core for n ticks, n = ticks capped at MAX_TICKS, then the result word is registered.
// A new word is taken only once the last result is registered; in S_RUN the core advances one tick per clock.
// A result may wait in the output register while the next word is taken.
// Reset (rst, synchronous): divider to 0xABCC, counter, edge, delay and
// configuration to zero, sequencer idle, no result pending.
module divider_edge_timer_with_reload_top #(
  parameter int RELOAD_DELAY = 3,
  parameter int MAX_TICKS    = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dtr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // [5:0] ticks
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [23:0]                   m_tdata   // [7:0] divider_high, [15:8] count_value,
                                                  // [16] overflow_irq
);
  import dtr_pkg::*;

  `include "divider_edge_timer_with_reload_top_defines.svh"

  localparam int RW = $clog2(MAX_TICKS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_PUSH
  } state_t;

  state_t               state;
  logic [RW-1:0]        remaining;
  logic                 irq_acc;
  logic                 tick;
  logic [TICKS_EXT_W-1:0] ticks_ext;
  logic [TICKS_EXT_W-1:0] ticks_sat;
  logic                 in_take;
  logic                 out_free;
  dtr_cfg_t             cfg;
  dtr_status_t          status;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Cap the tick count
  assign ticks_ext = {1'b0, s_tdata[TICKS_W-1:0]};
  assign ticks_sat = (ticks_ext > TICKS_EXT_W'(MAX_TICKS)) ? TICKS_EXT_W'(MAX_TICKS)
                                                            : ticks_ext;

  assign s_tready = (state == S_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign tick     = (state == S_RUN);
  assign out_free = !m_tvalid || m_tready;

  dtr_core #(
    .RELOAD_DELAY(RELOAD_DELAY)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .tick   (tick),
    .status (status)
  );

  // Sequence the ticks and register the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      remaining <= '0;
      irq_acc   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // Raise the result word, or drop it once taken
      if (state == S_PUSH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            irq_acc   <= 1'b0;
            remaining <= ticks_sat[RW-1:0];
            state     <= (ticks_sat == '0) ? S_PUSH : S_RUN;
          end
        end
        S_RUN: begin
          if (status.tick_irq) begin
            irq_acc <= 1'b1;
          end
          remaining <= remaining - RW'(1);
          if (remaining == RW'(1)) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            m_tdata  <= {7'd0, irq_acc, status.count_value, status.divider_high};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DTR_ASSERT_NEXT(a_run_after_take, in_take && s_tdata[TICKS_W-1:0] != '0, state == S_RUN)
  `DTR_ASSERT_SAME(a_remaining_range, state == S_RUN,
                   remaining != '0 && remaining <= RW'(MAX_TICKS))
  `DTR_ASSERT_NEXT(a_push_loads, state == S_PUSH && out_free, m_tvalid && state == S_IDLE)

endmodule

/* verif/tb_top.sv */
// Self-checking bench for the divider edge timer: tick items in, timer status words out.
`timescale 1ns / 100ps

module tb_top;
  import dtr_pkg::*;

  localparam int RELOAD_DELAY  = 3;
  localparam int MAX_TICKS     = 32;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_OFF_LEN  = 400;
  localparam int PHASE_WORDS   = 90;
  localparam int RANDOM_PHASES = 12;

  // Clock-select codes
  localparam logic [1:0] CLK_SEL_BIT9 = 2'd0;
  localparam logic [1:0] CLK_SEL_BIT3 = 2'd1;
  localparam logic [1:0] CLK_SEL_BIT5 = 2'd2;
  localparam logic [1:0] CLK_SEL_BIT7 = 2'd3;

  // Index past the register list; writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] divider_high;
    logic [BYTE_W-1:0] count_value;
    logic              overflow_irq;
  } timer_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [5:0] ticks
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;        // [7:0] divider_high, [15:8] count_value,
                                         // [16] overflow_irq

  // Timer mirror: configuration and state
  logic              enable_cfg = 1'b0;
  logic [1:0]        select_cfg = CLK_SEL_BIT9;
  logic [BYTE_W-1:0] reload_cfg = '0;
  logic [DIV_W-1:0]  div_q = DIV_RESET;
  logic [BYTE_W-1:0] count_q = '0;
  logic              edge_q = 1'b0;
  logic [2:0]        delay_q = '0;

  logic [5:0]  pending_ticks[$];
  timer_word_t expected_words[$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int mismatch_count = 0;
  int words_sent = 0;
  int words_checked = 0;
  int irq_words = 0;
  int hold_cnt = 0;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;

  divider_edge_timer_with_reload_top #(
    .RELOAD_DELAY(RELOAD_DELAY),
    .MAX_TICKS   (MAX_TICKS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // Advance the mirror by one word's ticks and queue the status it should report
  function automatic void advance_timer(input logic [5:0] ticks_in);
    int          n;
    int          i;
    int          pos;
    logic        level;
    timer_word_t w;
    n = (ticks_in > MAX_TICKS) ? MAX_TICKS : int'(ticks_in);
    w.overflow_irq = 1'b0;
    for (i = 0; i < n; i++) begin
      div_q = div_q + 1'b1;
      if (delay_q != 0) begin
        // freeze edge detection while the reload is pending
        delay_q = delay_q - 1'b1;
        if (delay_q == 0) begin
          count_q = reload_cfg;
          w.overflow_irq = 1'b1;
        end
      end else begin
        case (select_cfg)
          CLK_SEL_BIT9: pos = TAP_SEL0;
          CLK_SEL_BIT3: pos = TAP_SEL1;
          CLK_SEL_BIT5: pos = TAP_SEL2;
          CLK_SEL_BIT7: pos = TAP_SEL3;
          default:      pos = TAP_SEL3;
        endcase
        level = div_q[pos] & enable_cfg;
        if (edge_q && !level) begin
          if (count_q == COUNT_MAX) begin
            count_q = '0;
            delay_q = 3'(RELOAD_DELAY);
          end else begin
            count_q = count_q + 1'b1;
          end
        end
        edge_q = level;
      end
    end
    w.divider_high = div_q[DIV_W-1 -: BYTE_W];
    w.count_value  = count_q;
    expected_words.push_back(w);
  endfunction

  function automatic void report_mismatch(input string what, input timer_word_t want,
                                          input logic [23:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"[%0t] %s: expected div_hi=%02h count=%02h irq=%0b,",
                " got div_hi=%02h count=%02h irq=%0b"},
               $realtime, what, want.divider_high, want.count_value, want.overflow_irq,
               got[7:0], got[15:8], got[16]);
  endfunction

  // Sender: offer queued words, hold each until taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_timer(s_tdata[5:0]);
        words_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_ticks.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {2'b00, pending_ticks.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each status word against the oldest expectation
  always @(posedge clk) begin
    timer_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        words_checked++;
        if (m_tdata[16])
          irq_words++;
        if (expected_words.size() == 0) begin
          want = '0;
          report_mismatch("unexpected word", want, m_tdata);
        end else begin
          want = expected_words.pop_front();
          if (m_tdata[7:0] !== want.divider_high || m_tdata[15:8] !== want.count_value ||
              m_tdata[16] !== want.overflow_irq)
            report_mismatch("status mismatch", want, m_tdata);
        end
      end
      // long hold-off once, so the block backs up into its input
      if (hold_off_req && !hold_off_done) begin
        hold_off_done <= 1'b1;
        hold_cnt      <= HOLD_OFF_LEN;
        m_tready      <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("divider_edge_timer_with_reload_top test failed");
    $finish;
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TIMER_ENABLE: enable_cfg = val[0];
      REG_CLOCK_SELECT: select_cfg = val[1:0];
      REG_RELOAD_VALUE: reload_cfg = val;
      default: ;
    endcase
  endtask

  // Wait until every queued word is taken and every status word is back
  task automatic wait_drained();
    while (pending_ticks.size() > 0 || s_tvalid || expected_words.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int p;
    int k;
    int r;
    logic [7:0] reload_pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Timer disabled after reset: divider runs, counter holds
    pending_ticks = {6'd0, 6'd1, 6'd63, 6'd32};
    wait_drained();

    // Fast tap, reload at the top so overflows come every edge
    write_reg(REG_TIMER_ENABLE, 8'h01);
    write_reg(REG_CLOCK_SELECT, {6'b0, CLK_SEL_BIT3});
    write_reg(REG_RELOAD_VALUE, 8'hFF);
    write_reg(REG_UNUSED, 8'h00);
    pending_ticks = {6'd33, 6'd17, 6'd16, 6'd15, 6'd32, 6'd32, 6'd32, 6'd62, 6'd1, 6'd2,
                     6'd3, 6'd4, 6'd5, 6'd8, 6'd0, 6'd48};
    wait_drained();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      // sender idles lightly first, then the receiver, then neither
      if (p < 4) begin
        src_idle_pct = 11;
        snk_idle_pct = 78;
      end else if (p < 8) begin
        src_idle_pct = 78;
        snk_idle_pct = 11;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case (p % 4)
        0:       reload_pick = 8'hFF;
        1:       reload_pick = 8'h00;
        2:       reload_pick = 8'hFE;
        default: reload_pick = 8'($urandom_range(255));
      endcase
      write_reg(REG_TIMER_ENABLE, {7'($urandom), (p != 5)});
      write_reg(REG_CLOCK_SELECT, {6'($urandom), 2'(p % 4)});
      write_reg(REG_RELOAD_VALUE, reload_pick);
      if (p == 7)
        write_reg(REG_UNUSED, 8'($urandom));
      for (k = 0; k < PHASE_WORDS; k++) begin
        r = $urandom_range(99);
        if (r < 5)
          pending_ticks.push_back(6'd0);
        else if (r < 15)
          pending_ticks.push_back(6'($urandom_range(63, MAX_TICKS + 1)));
        else
          pending_ticks.push_back(6'($urandom_range(MAX_TICKS, 1)));
      end
      if (p == 8)
        hold_off_req = 1'b1;
      wait_drained();
    end

    // Let any stray word surface before the verdict
    repeat (MAX_TICKS + 8) @(posedge clk);
    $display("Covered %0d tick words over %0d timer settings, all taps, reload extremes.",
             words_sent, RANDOM_PHASES + 2);
    $display("Checked %0d status words, %0d with a completed reload, %0d mismatches.",
             words_checked, irq_words, mismatch_count);
    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("divider_edge_timer_with_reload_top test passed");
    else
      $display("divider_edge_timer_with_reload_top test failed");
    $finish;
  end

endmodule
